/* src/polyline_arc_length_resampler_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the polyline arc-length resampler
// Shared concurrent assertion wrappers used by the checker.
// ---------------------------------------------------------------------------
`ifndef POLYLINE_ARC_LENGTH_RESAMPLER_MACROS_SVH
`define POLYLINE_ARC_LENGTH_RESAMPLER_MACROS_SVH

// Check a property on every clock edge outside reset.
`define PLAR_ASSERT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("plar assertion failed");

// Check a property on every clock edge, reset included.
`define PLAR_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("plar assertion failed");

`endif

/* src/plar_pkg.sv */
// ---------------------------------------------------------------------------
// plar_pkg
// Types and constants shared by the arc-length resampler modules.
// ---------------------------------------------------------------------------
package plar_pkg;

  localparam int CoordW = 32;

  // Vertex as queued between front and back.
  typedef struct packed {
    logic                     first;
    logic                     final_vertex;
    logic signed [CoordW-1:0] pz;
    logic signed [CoordW-1:0] py;
    logic signed [CoordW-1:0] px;
  } vtx_t;

  // Handshake from back to front.
  typedef struct packed {
    logic ready;
  } back_stat_t;

endpackage

/* src/plar_front.sv */
// ---------------------------------------------------------------------------
// plar_front
// Accept vertices, tag the first one of each curve, queue two deep.
// ---------------------------------------------------------------------------
module plar_front
  import plar_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [3*CoordW-1:0] in_data_i,
  input  logic               in_last_i,
  output logic               q_valid_o,
  output vtx_t               q_vtx_o,
  input  back_stat_t         back_i
);

  vtx_t       ent_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       started_q;
  logic       push, pop;
  vtx_t       new_vtx;

  assign in_ready_o = (cnt_q != 2'd2);
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign pop        = q_valid_o && back_i.ready;
  assign q_vtx_o    = ent_q[rp_q];

  always_comb begin
    new_vtx.first        = !started_q;
    new_vtx.final_vertex = in_last_i;
    new_vtx.px           = in_data_i[CoordW-1:0];
    new_vtx.py           = in_data_i[2*CoordW-1:CoordW];
    new_vtx.pz           = in_data_i[3*CoordW-1:2*CoordW];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q      <= 1'b0;
      rp_q      <= 1'b0;
      cnt_q     <= 2'd0;
      started_q <= 1'b0;
    end else begin
      if (push) begin
        wp_q      <= !wp_q;
        started_q <= !in_last_i;
      end
      if (pop) begin
        rp_q <= !rp_q;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wp_q] <= new_vtx;
    end
  end

endmodule

/* src/plar_back.sv */
// ---------------------------------------------------------------------------
// plar_back
// Walk one vertex with serial square, root, multiply and divide units,
// buffer its results, then drain them to the output stream.
// ---------------------------------------------------------------------------
module plar_back
  import plar_pkg::*;
#(
  parameter int MAX_STEPS_PER_VERTEX = 63
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  vtx_t                q_vtx_i,
  output back_stat_t          back_o,
  input  logic [30:0]         step_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [3*CoordW-1:0] out_data_o,
  output logic                out_last_o,
  output logic [1:0]          out_user_o
);

  localparam int Depth = MAX_STEPS_PER_VERTEX + 1;
  localparam int AW    = $clog2(Depth);
  localparam int MemW  = 3*CoordW + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_DELTA, S_SQ, S_ROOT0, S_ROOT, S_CHK, S_MUL, S_DIV0, S_DIV,
    S_INTERP, S_EMIT, S_AFTER, S_RD, S_OUT
  } state_e;

  state_e state_q;
  logic [5:0]    cnt_q;
  logic [AW-1:0] k_q;
  logic [AW:0]   wcnt_q;
  logic [AW-1:0] ridx_q;
  logic          ovf_q, fin_q;
  logic [32:0]   acc_q;

  logic signed [31:0] v_q [3];
  logic signed [31:0] anc_q [3];
  logic signed [31:0] held_q [3];
  logic signed [31:0] nx_q [3];
  logic        neg_q [3];
  logic [32:0] mag_q [3];
  logic [65:0] ma_q [3];
  logic [32:0] mb_q [3];
  logic [65:0] prod_q [3];
  logic [67:0] sq_q;
  logic [34:0] rem_q;
  logic [33:0] root_q;
  logic [34:0] drem_q [3];
  logic [32:0] dlow_q [3];
  logic [32:0] quo_q [3];

  logic [MemW-1:0] mem [Depth];
  logic [MemW-1:0] rd_q;
  logic            we;
  logic [MemW-1:0] wdata;

  logic [30:0] step_eff;
  logic [34:0] dsum;
  logic        below, r_zero, last_out;
  logic [31:0] r_val;
  logic [36:0] rrem2;
  logic [35:0] rtrial;
  logic [AW:0] total;

  assign step_eff = (step_i == 31'd0) ? 31'd1 : step_i;
  assign dsum     = {2'b00, acc_q} + {1'b0, root_q};
  assign below    = dsum < {4'b0000, step_eff};
  assign r_val    = (acc_q < {2'b00, step_eff}) ? 32'({2'b00, step_eff} - acc_q) : 32'd0;
  assign r_zero   = (r_val == 32'd0) || (root_q == 34'd0);
  assign rrem2    = {rem_q, sq_q[67:66]};
  assign rtrial   = {root_q, 2'b01};
  assign total    = wcnt_q + {{AW{1'b0}}, fin_q};
  assign last_out = ({1'b0, ridx_q} == (wcnt_q - 1'b1));

  assign back_o.ready = (state_q == S_IDLE);
  assign out_valid_o  = (state_q == S_OUT);
  assign out_data_o   = rd_q[3*CoordW-1:0];
  assign out_last_o   = last_out;
  assign out_user_o   = {ovf_q, rd_q[MemW-1]};

  always_comb begin
    we    = 1'b0;
    wdata = {1'b0, held_q[2], held_q[1], held_q[0]};
    if (state_q == S_EMIT) begin
      we = 1'b1;
    end else if (state_q == S_AFTER && fin_q) begin
      we    = 1'b1;
      wdata = {1'b1, v_q[2], v_q[1], v_q[0]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wcnt_q[AW-1:0]] <= wdata;
    end
    if (state_q == S_RD) begin
      rd_q <= mem[ridx_q];
    end
  end

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      k_q     <= '0;
      wcnt_q  <= '0;
      ridx_q  <= '0;
      ovf_q   <= 1'b0;
      fin_q   <= 1'b0;
      acc_q   <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (q_valid_i) begin
            fin_q  <= q_vtx_i.final_vertex;
            ovf_q  <= 1'b0;
            wcnt_q <= '0;
            k_q    <= '0;
            if (q_vtx_i.first) begin
              acc_q   <= '0;
              state_q <= S_AFTER;
            end else begin
              state_q <= S_DELTA;
            end
          end
        end
        S_DELTA: begin
          cnt_q   <= '0;
          state_q <= S_SQ;
        end
        S_SQ: begin
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'd32) state_q <= S_ROOT0;
        end
        S_ROOT0: begin
          cnt_q   <= '0;
          state_q <= S_ROOT;
        end
        S_ROOT: begin
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'd33) state_q <= S_CHK;
        end
        S_CHK: begin
          cnt_q <= '0;
          if (below) begin
            acc_q   <= dsum[32:0];
            state_q <= S_AFTER;
          end else if (k_q == AW'(MAX_STEPS_PER_VERTEX)) begin
            ovf_q   <= 1'b1;
            acc_q   <= '0;
            state_q <= S_AFTER;
          end else if (r_zero) begin
            state_q <= S_EMIT;
          end else begin
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'd32) state_q <= S_DIV0;
        end
        S_DIV0: begin
          cnt_q   <= '0;
          state_q <= S_DIV;
        end
        S_DIV: begin
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'd32) state_q <= S_INTERP;
        end
        S_INTERP: state_q <= S_EMIT;
        S_EMIT: begin
          wcnt_q  <= wcnt_q + 1'b1;
          k_q     <= k_q + 1'b1;
          acc_q   <= '0;
          state_q <= S_DELTA;
        end
        S_AFTER: begin
          wcnt_q <= total;
          ridx_q <= '0;
          state_q <= (total != '0) ? S_RD : S_IDLE;
        end
        S_RD: state_q <= S_OUT;
        S_OUT: begin
          if (out_ready_i) begin
            if (last_out) begin
              state_q <= S_IDLE;
            end else begin
              ridx_q  <= ridx_q + 1'b1;
              state_q <= S_RD;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    logic [32:0] dx;
    logic [63:0] num;
    logic [34:0] drem2;
    unique case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          v_q[0] <= q_vtx_i.px;
          v_q[1] <= q_vtx_i.py;
          v_q[2] <= q_vtx_i.pz;
          if (q_vtx_i.first) begin
            anc_q[0]  <= q_vtx_i.px;
            anc_q[1]  <= q_vtx_i.py;
            anc_q[2]  <= q_vtx_i.pz;
            held_q[0] <= q_vtx_i.px;
            held_q[1] <= q_vtx_i.py;
            held_q[2] <= q_vtx_i.pz;
          end
        end
      end
      S_DELTA: begin
        for (int a = 0; a < 3; a++) begin
          dx = {v_q[a][31], v_q[a]} - {anc_q[a][31], anc_q[a]};
          neg_q[a]  <= dx[32];
          mag_q[a]  <= dx[32] ? (33'd0 - dx) : dx;
          ma_q[a]   <= {33'd0, (dx[32] ? (33'd0 - dx) : dx)};
          mb_q[a]   <= dx[32] ? (33'd0 - dx) : dx;
          prod_q[a] <= '0;
        end
      end
      S_SQ, S_MUL: begin
        for (int a = 0; a < 3; a++) begin
          if (mb_q[a][0]) prod_q[a] <= prod_q[a] + ma_q[a];
          ma_q[a] <= {ma_q[a][64:0], 1'b0};
          mb_q[a] <= {1'b0, mb_q[a][32:1]};
        end
      end
      S_ROOT0: begin
        sq_q   <= {2'b00, prod_q[0]} + {2'b00, prod_q[1]} + {2'b00, prod_q[2]};
        rem_q  <= '0;
        root_q <= '0;
      end
      S_ROOT: begin
        if (rrem2 >= {1'b0, rtrial}) begin
          rem_q  <= 35'(rrem2 - {1'b0, rtrial});
          root_q <= {root_q[32:0], 1'b1};
        end else begin
          rem_q  <= rrem2[34:0];
          root_q <= {root_q[32:0], 1'b0};
        end
        sq_q <= {sq_q[65:0], 2'b00};
      end
      S_CHK: begin
        for (int a = 0; a < 3; a++) begin
          ma_q[a]   <= {33'd0, mag_q[a]};
          mb_q[a]   <= {1'b0, r_val};
          prod_q[a] <= '0;
          nx_q[a]   <= anc_q[a];
        end
        if (below || k_q == AW'(MAX_STEPS_PER_VERTEX)) begin
          for (int a = 0; a < 3; a++) anc_q[a] <= v_q[a];
        end
      end
      S_DIV0: begin
        for (int a = 0; a < 3; a++) begin
          num = prod_q[a][63:0] + {31'd0, root_q[33:1]};
          drem_q[a] <= {4'd0, num[63:33]};
          dlow_q[a] <= num[32:0];
          quo_q[a]  <= '0;
        end
      end
      S_DIV: begin
        for (int a = 0; a < 3; a++) begin
          drem2 = {drem_q[a][33:0], dlow_q[a][32]};
          if (drem2 >= {1'b0, root_q}) begin
            drem_q[a] <= drem2 - {1'b0, root_q};
            quo_q[a]  <= {quo_q[a][31:0], 1'b1};
          end else begin
            drem_q[a] <= drem2;
            quo_q[a]  <= {quo_q[a][31:0], 1'b0};
          end
          dlow_q[a] <= {dlow_q[a][31:0], 1'b0};
        end
      end
      S_INTERP: begin
        for (int a = 0; a < 3; a++) begin
          nx_q[a] <= neg_q[a] ? (anc_q[a] - signed'(quo_q[a][31:0]))
                              : (anc_q[a] + signed'(quo_q[a][31:0]));
        end
      end
      S_EMIT: begin
        for (int a = 0; a < 3; a++) begin
          held_q[a] <= nx_q[a];
          anc_q[a]  <= nx_q[a];
        end
      end
      default: begin
      end
    endcase
  end

endmodule

/* src/polyline_arc_length_resampler.sv */
// ---------------------------------------------------------------------------
// polyline_arc_length_resampler
// Resample a streamed polyline into points one step of arc length apart.
// ---------------------------------------------------------------------------
// Vertices (signed Q16.16 x,y,z) enter one per item on the s_axis side, tlast
// marking the last vertex of a polyline. The first vertex of a curve is the
// first point; each later vertex walks its segment and generates a point
// every step_length of arc length, releasing the previously generated point.
// On the last vertex the endpoint replaces the point still held back. At most
// MAX_STEPS_PER_VERTEX points are generated per vertex; beyond that the rest
// of the segment is skipped and tuser[1] (overflow) is set on all its results.
// A two-entry input queue takes vertices while the walk engine works. The
// engine uses bit-serial units: each segment-length evaluation runs a squarer
// and then a root, plus setup and compare, and each generated point runs a
// multiply and then a divide, plus setup and update, before the next
// evaluation; the multiply and divide are skipped when the point lands on the
// anchor. The buffered results then drain one at a time, each read from the
// buffer before it is offered; the engine takes the next vertex only after
// the drain. step_length sits at byte address 0 of the APB port.
// ---------------------------------------------------------------------------
module polyline_arc_length_resampler
  import plar_pkg::*;
#(
  parameter int MAX_STEPS_PER_VERTEX = 63,
  parameter int COORD_FRAC_BITS      = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Vertex input
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,  // px[31:0], py[63:32], pz[95:64]
  input  logic        s_axis_tlast,  // final_vertex
  // Point output
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [95:0] m_axis_tdata,  // qx[31:0], qy[63:32], qz[95:64]
  output logic        m_axis_tlast,  // run_end
  output logic [1:0]  m_axis_tuser,  // curve_end[0], overflow[1]
  // Configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Default step is about 0.05 in the coordinate format.
  localparam logic [30:0] StepReset =
    31'(((64'd1 << COORD_FRAC_BITS) + 64'd10) / 64'd20);
  localparam logic [2:0] AddrStep = 3'd0;

  logic [30:0] step_q;
  logic        q_valid;
  vtx_t        q_vtx;
  back_stat_t  back_stat;

  assign pready = 1'b1;
  assign prdata = (paddr == AddrStep) ? {1'b0, step_q} : 32'd0;

  // Take step_length writes; unknown addresses are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= StepReset;
    end else if (psel && penable && pwrite && pready && paddr == AddrStep) begin
      step_q <= pwdata[30:0];
    end
  end

  plar_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_data_i  (s_axis_tdata),
    .in_last_i  (s_axis_tlast),
    .q_valid_o  (q_valid),
    .q_vtx_o    (q_vtx),
    .back_i     (back_stat)
  );

  plar_back #(
    .MAX_STEPS_PER_VERTEX (MAX_STEPS_PER_VERTEX)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_vtx_i     (q_vtx),
    .back_o      (back_stat),
    .step_i      (step_q),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast),
    .out_user_o  (m_axis_tuser)
  );

endmodule

/* src/plar_checker.sv */
// ---------------------------------------------------------------------------
// plar_checker
// Port-level checks on the resampler output stream.
// ---------------------------------------------------------------------------
`include "polyline_arc_length_resampler_macros.svh"

module plar_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [95:0] m_axis_tdata,
  input logic        m_axis_tlast,
  input logic [1:0]  m_axis_tuser
);

  // Stalled result holds.
  `PLAR_ASSERT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
  // The endpoint always closes its vertex's run.
  `PLAR_ASSERT(a_cend_last, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast)
  // Overflow stays the same across one vertex's run.
  `PLAR_ASSERT(a_ovf_run, clk_i, rst_ni, m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> !m_axis_tvalid || m_axis_tuser[1] == $past(m_axis_tuser[1]))
  // Nothing leaves right out of reset.
  `PLAR_ASSERT_ALWAYS(a_rst_quiet, clk_i, !rst_ni |=> !m_axis_tvalid)

endmodule

bind polyline_arc_length_resampler plar_checker u_plar_checker (.*);

/* dv/tb.sv */
// ---------------------------------------------------------------------------
// tb - polyline arc-length resampler testbench
// Streams polylines through the resampler and checks every output point
// against a cycle-free predictor of the arc-length walk, under random
// stalls on both streams and several step_length settings.
// ---------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MaxSteps    = 63;
  localparam int StepReset   = 3277;
  localparam int StepMax     = 32'h7FFF_FFFF;
  localparam int DrainCycles = 600;     // two queued no-crossing vertices, with margin
  localparam int WatchLimit  = 100000;  // longer than the slowest overflow vertex
  localparam logic [2:0] AddrStep = 3'd0;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        run_end;
    logic        curve_end;
    logic        ovf;
  } point_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata = '0;  // px[31:0], py[63:32], pz[95:64]
  logic        s_axis_tlast = 1'b0;  // final_vertex
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [95:0] m_axis_tdata;  // qx[31:0], qy[63:32], qz[95:64]
  logic        m_axis_tlast;  // run_end
  logic [1:0]  m_axis_tuser;  // curve_end[0], overflow[1]
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  polyline_arc_length_resampler u_top (.*);

  always #5ns clk_i = ~clk_i;

  // Predictor state: walk anchor, held-back point, distance since anchor
  longint      anc_x, anc_y, anc_z;
  longint      held_x, held_y, held_z;
  longint      walked;
  bit          in_curve;
  longint      step_reg = StepReset;

  point_t      expected_points[$];
  int          errors = 0;
  int          vertices_sent = 0;
  int          points_checked = 0;
  int          overflow_points = 0;
  int          burst_left = 0;

  // floor(sqrt) of the squared segment length, exact over 33-bit deltas
  function automatic longint seg_len(longint dx, longint dy, longint dz);
    logic [127:0] sum, c;
    logic [63:0]  root;
    longint       ax, ay, az;
    ax = dx < 0 ? -dx : dx;
    ay = dy < 0 ? -dy : dy;
    az = dz < 0 ? -dz : dz;
    sum = 128'(ax) * 128'(ax) + 128'(ay) * 128'(ay) + 128'(az) * 128'(az);
    root = '0;
    for (int b = 34; b >= 0; b--) begin
      c = 128'(root | (64'd1 << b));
      if (c * c <= sum) root = c[63:0];
    end
    return longint'(root);
  endfunction

  // anchor + delta*r/d, magnitude rounded half away from zero
  function automatic longint lerp_axis(longint a, longint b, longint r, longint d);
    longint       delta;
    logic [127:0] q;
    delta = b - a;
    q = (128'(delta < 0 ? -delta : delta) * 128'(r) + 128'(d / 2)) / 128'(d);
    return delta < 0 ? a - longint'(q) : a + longint'(q);
  endfunction

  function automatic point_t mk_point(longint x, longint y, longint z, bit cend);
    point_t p;
    p.x = x[31:0];
    p.y = y[31:0];
    p.z = z[31:0];
    p.run_end = 1'b0;
    p.curve_end = cend;
    p.ovf = 1'b0;
    return p;
  endfunction

  // Walk one accepted vertex and queue the points it releases
  task automatic predict_vertex(logic [31:0] px, logic [31:0] py, logic [31:0] pz, bit fin);
    longint vx, vy, vz, d, r, nx, ny, nz, stp;
    point_t res[$];
    bit     ovf;
    vx = longint'($signed(px));
    vy = longint'($signed(py));
    vz = longint'($signed(pz));
    ovf = 1'b0;
    if (!in_curve) begin
      anc_x = vx; anc_y = vy; anc_z = vz;
      held_x = vx; held_y = vy; held_z = vz;
      walked = 0;
      in_curve = 1'b1;
      if (fin) begin
        res = {res, mk_point(vx, vy, vz, 1'b1)};
        in_curve = 1'b0;
      end
    end else begin
      stp = step_reg == 0 ? 1 : step_reg;
      for (int k = 0; k <= MaxSteps; k++) begin
        d = seg_len(vx - anc_x, vy - anc_y, vz - anc_z);
        if (walked + d < stp) begin
          anc_x = vx; anc_y = vy; anc_z = vz;
          walked += d;
          break;
        end
        // too many crossings: skip the rest of the segment
        if (k == MaxSteps) begin
          ovf = 1'b1;
          anc_x = vx; anc_y = vy; anc_z = vz;
          walked = 0;
          break;
        end
        r = walked < stp ? stp - walked : 0;
        if (r == 0 || d == 0) begin
          nx = anc_x; ny = anc_y; nz = anc_z;
        end else begin
          nx = lerp_axis(anc_x, vx, r, d);
          ny = lerp_axis(anc_y, vy, r, d);
          nz = lerp_axis(anc_z, vz, r, d);
        end
        res = {res, mk_point(held_x, held_y, held_z, 1'b0)};
        held_x = nx; held_y = ny; held_z = nz;
        anc_x = nx; anc_y = ny; anc_z = nz;
        walked = 0;
      end
      // endpoint replaces the held point
      if (fin) begin
        res = {res, mk_point(vx, vy, vz, 1'b1)};
        in_curve = 1'b0;
      end
    end
    foreach (res[i]) begin
      res[i].ovf = ovf;
      res[i].run_end = (i == res.size() - 1);
      expected_points = {expected_points, res[i]};
    end
  endtask

  // Send one vertex; bursts of back-to-back items with random gaps between
  task automatic send_vertex(longint x, longint y, longint z, bit fin);
    bit hit;
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = $urandom_range(1, 10);
    end
    burst_left--;
    s_axis_tdata  <= {z[31:0], y[31:0], x[31:0]};
    s_axis_tlast  <= fin;
    s_axis_tvalid <= 1'b1;
    do begin
      @(negedge clk_i);
      hit = s_axis_tready;
      if (hit) predict_vertex(x[31:0], y[31:0], z[31:0], fin);
      @(posedge clk_i);
    end while (!hit);
    vertices_sent++;
  endtask

  // Drop valid, let every expected point arrive and the engine settle
  task automatic wait_idle();
    burst_left = 0;
    s_axis_tvalid <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_step(longint value);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= AddrStep; pwdata <= value[31:0];
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    step_reg = value & 64'h7FFF_FFFF;
  endtask

  // Receiver stalls: always ready, coin flips, or long stalls, per window
  int stall_mode = 0;
  int stall_cnt = 0;
  always @(posedge clk_i) begin
    stall_cnt <= stall_cnt + 1;
    if (stall_cnt % 256 == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= $urandom_range(0, 1);
      default: m_axis_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  task automatic check_field(string name, logic [31:0] e, logic [31:0] a);
    if (e !== a) begin
      $display("%0t: mismatch %s expected %h actual %h", $time, name, e, a);
      errors++;
    end
  endtask

  // Check each point on the cycle it is accepted
  always @(negedge clk_i) begin
    point_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_points.size() == 0) begin
        $display("%0t: unexpected point expected none actual %h", $time, m_axis_tdata);
        errors++;
      end else begin
        e = expected_points.pop_front();
        check_field("qx", e.x, m_axis_tdata[31:0]);
        check_field("qy", e.y, m_axis_tdata[63:32]);
        check_field("qz", e.z, m_axis_tdata[95:64]);
        check_field("run_end", 32'(e.run_end), 32'(m_axis_tlast));
        check_field("curve_end", 32'(e.curve_end), 32'(m_axis_tuser[0]));
        check_field("overflow", 32'(e.ovf), 32'(m_axis_tuser[1]));
        if (e.ovf) overflow_points++;
      end
      points_checked++;
    end
  end

  // Watchdog: too long with no item moving on either stream
  int quiet = 0;
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet > WatchLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // ---- tests --------------------------------------------------------------

  // Single-vertex polylines, the field extremes among them
  task automatic test_single_vertex();
    send_vertex(0, 0, 0, 1'b1);
    send_vertex(-64'sh8000_0000, 64'sh7FFF_FFFF, -64'sh8000_0000, 1'b1);
    send_vertex(64'sh7FFF_FFFF, -64'sh8000_0000, 64'sh7FFF_FFFF, 1'b1);
  endtask

  // Curve shorter than one step: only the endpoint comes out
  task automatic test_short_curve();
    send_vertex(1000, 2000, 3000, 1'b0);
    send_vertex(1100, 2050, 2990, 1'b0);
    send_vertex(1200, 2000, 3000, 1'b1);
  endtask

  // Corner to corner of the coordinate cube at the largest step
  task automatic test_full_range();
    wait_idle();
    write_step(StepMax);
    send_vertex(-64'sh8000_0000, -64'sh8000_0000, -64'sh8000_0000, 1'b0);
    send_vertex(64'sh7FFF_FFFF, 64'sh7FFF_FFFF, 64'sh7FFF_FFFF, 1'b0);
    send_vertex(-64'sh8000_0000, 64'sh7FFF_FFFF, -64'sh8000_0000, 1'b1);
  endtask

  // Lower the step under the distance already walked, mid curve
  task automatic test_step_lowered();
    wait_idle();
    write_step(65536 * 100);
    send_vertex(0, 0, 0, 1'b0);
    send_vertex(655360, 0, 0, 1'b0);
    wait_idle();
    write_step(300000);
    send_vertex(1310720, 0, 0, 1'b1);
  endtask

  // Unit step on a long segment runs past the per-vertex point cap
  task automatic test_overflow();
    wait_idle();
    write_step(1);
    send_vertex(0, 0, 0, 1'b0);
    send_vertex(1000, -500, 200, 1'b0);
    send_vertex(1010, -500, 200, 1'b1);
  endtask

  // Random polylines: random walks scaled to the step, plus some wild vertices
  task automatic test_random(int n_items);
    longint steps[4];
    longint x, y, z, stp, span, nv;
    int     len, sent;
    steps = '{StepReset, 1000, 65536, 0};
    sent = 0;
    for (int ph = 0; ph < 4; ph++) begin
      wait_idle();
      stp = ph == 3 ? longint'($urandom_range(2000, 1 << 20)) : steps[ph];
      write_step(stp);
      while (sent < (ph + 1) * n_items / 4) begin
        len = $urandom_range(1, 8);
        x = longint'($signed($urandom));
        y = longint'($signed($urandom));
        z = longint'($signed($urandom));
        for (int v = 0; v < len; v++) begin
          if (v > 0) begin
            if ($urandom_range(0, 39) == 0) begin
              x = longint'($signed($urandom));
              y = longint'($signed($urandom));
              z = longint'($signed($urandom));
            end else begin
              span = ($urandom_range(0, 9) == 0) ? stp * 30 : stp * 3;
              for (int a = 0; a < 3; a++) begin
                nv = longint'($urandom_range(0, 32'(2 * span))) - span;
                nv += a == 0 ? x : (a == 1 ? y : z);
                // reflect the move instead of leaving the coordinate range
                if (nv > 64'sh7FFF_FFFF || nv < -64'sh8000_0000)
                  nv = 2 * (a == 0 ? x : (a == 1 ? y : z)) - nv;
                if (a == 0) x = nv; else if (a == 1) y = nv; else z = nv;
              end
            end
          end
          send_vertex(x, y, z, v == len - 1);
          sent++;
        end
      end
    end
  endtask

  initial begin
    anc_x = 0; anc_y = 0; anc_z = 0;
    held_x = 0; held_y = 0; held_z = 0;
    walked = 0;
    in_curve = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_single_vertex();
    test_short_curve();
    test_full_range();
    test_step_lowered();
    test_overflow();
    test_random(400);

    wait_idle();
    $display("Covered %0d vertices, %0d points checked, %0d with overflow set,",
             vertices_sent, points_checked, overflow_points);
    $display("steps from one raw unit up to the largest, random stalls both sides.");
    if (errors == 0 && expected_points.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+src
src/plar_pkg.sv
src/plar_front.sv
src/plar_back.sv
src/polyline_arc_length_resampler.sv
src/plar_checker.sv
dv/tb.sv
